// ===== rtl/core/slipd_pkg.sv =====
// Shared constants, codes and types of the SLIP frame decoder.
package slipd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 256;
  localparam int unsigned CHECK_BYTES      = 4;
  localparam int unsigned SUM_W            = 24;
  localparam int unsigned LEN_W            = 9;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t    status;
    logic             ready;
    logic [LEN_W-1:0] length;
    logic             overflow;
    logic             rd_hit;
  } slipd_res_t;

endpackage

// ===== rtl/core/slipd_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result items.
interface slipd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic [7:0] read_index;

  modport source (output valid, mode, data_byte, read_index, input ready);
  modport sink   (input valid, mode, data_byte, read_index, output ready);
endinterface

interface slipd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic       frame_ready;
  logic [8:0] frame_length;
  logic       overflow_seen;
  logic [7:0] read_value;

  modport source (output valid, frame_status, frame_ready, frame_length, overflow_seen,
                  read_value, input ready);
  modport sink   (input valid, frame_status, frame_ready, frame_length, overflow_seen,
                  read_value, output ready);
endinterface

// ===== rtl/core/slipd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module slipd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/slipd_frame.sv =====
// Frame state: unescaping, running sum, checksum test and payload RAM control.
module slipd_frame import slipd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  localparam int unsigned AW  = $clog2(BUFFER_BYTES),
  localparam int unsigned WPW = $clog2(BUFFER_BYTES + 1),
  localparam int unsigned CW  = (WPW > 8) ? WPW : 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          acc,
  input  logic          mode,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    read_index,
  output slipd_res_t    res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [7:0]    mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr
);

  logic             chk_r;
  logic [WPW-1:0]   wp_r, wp_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             held_r, held_nxt;
  logic             esc_r, esc_nxt;
  logic [31:0]      last4_r, last4_nxt;

  logic             store;
  logic [7:0]       sbyte;
  logic [9:0]       tail_sum;
  logic [WPW-1:0]   len;
  frame_status_t    status;
  logic             ovf;

  assign tail_sum = 10'(last4_r[7:0]) + 10'(last4_r[15:8])
                  + 10'(last4_r[23:16]) + 10'(last4_r[31:24]);

  always_comb begin
    wp_nxt    = wp_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    esc_nxt   = esc_r;
    last4_nxt = last4_r;
    status    = ST_NONE;
    ovf       = 1'b0;
    store     = 1'b0;
    sbyte     = data_byte;
    mem_waddr = '0;
    if (mode == MODE_PUSH) begin
      // A push after a held frame drops it before the byte is handled.
      if (held_r) begin
        wp_nxt   = '0;
        sum_nxt  = '0;
        held_nxt = 1'b0;
      end
      if (wp_nxt == WPW'(BUFFER_BYTES)) begin
        wp_nxt   = '0;
        sum_nxt  = '0;
        held_nxt = 1'b0;
        ovf      = 1'b1;
      end
      if (esc_r) begin
        // Any escaped byte other than the two known codes is dropped.
        esc_nxt = 1'b0;
        if (data_byte == SLIP_ESC_END) begin
          store = 1'b1;
          sbyte = SLIP_END;
        end else if (data_byte == SLIP_ESC_ESC) begin
          store = 1'b1;
          sbyte = SLIP_ESC;
        end
      end else if (data_byte == SLIP_ESC) begin
        esc_nxt = 1'b1;
      end else if (data_byte == SLIP_END) begin
        if (!chk_r) begin
          held_nxt = 1'b1;
          status   = ST_ACCEPT;
        end else if (wp_nxt < WPW'(CHECK_BYTES)) begin
          wp_nxt   = '0;
          sum_nxt  = '0;
          held_nxt = 1'b0;
          status   = ST_REJECT;
        end else if ({8'd0, sum_nxt - SUM_W'(tail_sum)} == last4_r) begin
          wp_nxt   = wp_nxt - WPW'(CHECK_BYTES);
          held_nxt = 1'b1;
          status   = ST_ACCEPT;
        end else begin
          wp_nxt   = '0;
          sum_nxt  = '0;
          held_nxt = 1'b0;
          status   = ST_REJECT;
        end
      end else begin
        store = 1'b1;
      end
      if (store) begin
        mem_waddr = AW'(wp_nxt);
        wp_nxt    = wp_nxt + WPW'(1);
        sum_nxt   = sum_nxt + SUM_W'(sbyte);
        last4_nxt = {sbyte, last4_r[31:8]};
      end
    end
  end

  // With checking on, an open frame reports its count less the checksum bytes.
  always_comb begin
    if (held_nxt || !chk_r) begin
      len = wp_nxt;
    end else if (wp_nxt >= WPW'(CHECK_BYTES)) begin
      len = wp_nxt - WPW'(CHECK_BYTES);
    end else begin
      len = '0;
    end
  end

  assign mem_we    = acc && (mode == MODE_PUSH) && store;
  assign mem_wdata = sbyte;
  assign mem_re    = acc && (mode == MODE_READ);
  assign mem_raddr = AW'(read_index);

  assign res.status   = status;
  assign res.ready    = held_nxt;
  assign res.length   = LEN_W'(len);
  assign res.overflow = ovf;
  assign res.rd_hit   = (mode == MODE_READ) && (CW'(read_index) < CW'(len));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r   <= 1'b1;
      wp_r    <= '0;
      sum_r   <= '0;
      held_r  <= 1'b0;
      esc_r   <= 1'b0;
      last4_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        chk_r <= cfg_wr_data;
      end
      if (acc) begin
        wp_r    <= wp_nxt;
        sum_r   <= sum_nxt;
        held_r  <= held_nxt;
        esc_r   <= esc_nxt;
        last4_r <= last4_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/slip_frame_decoder_with_checksum_core.sv =====
// Top level of the SLIP frame decoder with byte-sum checksum.
//
//  channel  direction  handshake         payload
//  in_ch    input      valid/ready       mode, data_byte, read_index
//  out_ch   output     valid/ready       frame_status, frame_ready, frame_length,
//                                        overflow_seen, read_value
//  cfg_*    input      write enable only checksum_check_on
//
// One item is accepted per cycle while the output does not stall; its result is
// held in the middle stage beside the registered RAM read, then in the output register.
// Frame state updates in the cycle of acceptance, so items can follow back to back.
// Reset is synchronous and active low; it clears control state, not the payload RAM.
// A stalled result holds in the output register while one more item is accepted
// into the middle stage; after that the input stalls until the output is taken.
module slip_frame_decoder_with_checksum_core import slipd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  slipd_in_if.sink   in_ch,
  slipd_out_if.source out_ch
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  logic          acc;
  slipd_res_t    res;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic          s1_v_r;
  slipd_res_t    s1_res_r;
  logic          s1_adv;
  logic          out_v_r;
  slipd_res_t    out_res_r;
  logic [7:0]    out_rd_r;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  slipd_frame #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .acc        (acc),
    .mode       (in_ch.mode),
    .data_byte  (in_ch.data_byte),
    .read_index (in_ch.read_index),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  slipd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // The RAM read register only reloads on a read item, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_res_r <= s1_res_r;
      out_rd_r  <= s1_res_r.rd_hit ? mem_rdata : 8'd0;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.frame_status  = out_res_r.status;
  assign out_ch.frame_ready   = out_res_r.ready;
  assign out_ch.frame_length  = out_res_r.length;
  assign out_ch.overflow_seen = out_res_r.overflow;
  assign out_ch.read_value    = out_rd_r;

`ifndef SYNTHESIS
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.frame_status == ST_ACCEPT) |-> out_ch.frame_ready)
    else $error("accepted frame not reported as held");

  a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.frame_status == ST_REJECT)
      |-> !out_ch.frame_ready && (out_ch.frame_length == 9'd0))
    else $error("rejected frame left state behind");

  a_mid_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r)
    else $error("middle stage item lost while stalled");

  a_read_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_res_r.rd_hit
      |-> (out_ch.frame_status == ST_NONE) && !out_ch.overflow_seen)
    else $error("read item reported frame activity");
`endif

endmodule
